// ===== rtl/aabb_segment_slab_test_macros.svh =====
// Assertion macros shared by the segment versus box test.
`ifndef AABB_SEGMENT_SLAB_TEST_MACROS_SVH
`define AABB_SEGMENT_SLAB_TEST_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/aabb_pkg.sv =====
package aabb_pkg;
  // Per-axis slab classification after the first stage.
  localparam logic [1:0] AX_LIMIT = 2'd0;  // finite entry and exit
  localparam logic [1:0] AX_FREE  = 2'd1;  // zero direction, origin inside
  localparam logic [1:0] AX_MISS  = 2'd2;  // zero direction, origin outside
  localparam logic [1:0] AX_FACE  = 2'd3;  // zero direction, origin on a face

  typedef struct packed {
    logic       valid;
    logic       ready;
  } aabb_flow_t;
endpackage

// ===== rtl/aabb_stream_if.sv =====
interface aabb_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/aabb_segment_slab_test.sv =====
// Channel  | Direction | Payload
// in_req   | sink      | box_min/max xyz, seg_origin xyz, seg_dir xyz
// out_req  | source    | hit
// One request enters every cycle unless the output stalls; the stages
// are axis setup, two merge rounds and the final range tests, each round
// a registered product, compare and select. Reset (rst, synchronous)
// clears the valid bits only. A stall on the output freezes every stage
// at once, so nothing is lost or repeated; the output register holds.
module aabb_segment_slab_test
  import aabb_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic clk,
  input logic rst,
  aabb_stream_if.sink   in_req,
  aabb_stream_if.source out_req
);
`include "aabb_segment_slab_test_macros.svh"
  localparam int NB    = COORD_BITS + 2;
  localparam int DB    = COORD_BITS + 1;
  localparam int DEPTH = 10;
  // FRAC_BITS only names the format: the common scale cancels in every ratio.

  logic en;
  logic [DEPTH-1:0] vld;
  assign en = out_req.ready || !out_req.valid;
  assign in_req.ready = en;
  assign out_req.valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_req.valid};
  end

  // Stage 1: per-axis setup.
  logic signed [NB-1:0] nn [3];
  logic signed [NB-1:0] nf [3];
  logic        [DB-1:0] den [3];
  logic [1:0]           kind [3];
  for (genvar k = 0; k < 3; k++) begin : g_ax
    aabb_axis #(.CW(COORD_BITS)) u_ax (
      .clk(clk), .en(en),
      .lo(in_req.data[k*COORD_BITS +: COORD_BITS]),
      .hi(in_req.data[(3+k)*COORD_BITS +: COORD_BITS]),
      .org(in_req.data[(6+k)*COORD_BITS +: COORD_BITS]),
      .dir(in_req.data[(9+k)*COORD_BITS +: COORD_BITS]),
      .nn(nn[k]), .nf(nf[k]), .den(den[k]), .kind(kind[k]));
  end

  // Early decision: face hit beats everything, then a zero-direction miss.
  logic face1, miss1;
  logic fin1 [3];
  always_comb begin
    face1 = 1'b0;
    miss1 = 1'b0;
    for (int k = 0; k < 3; k++) begin
      face1 |= (kind[k] == AX_FACE);
      miss1 |= (kind[k] == AX_MISS);
      fin1[k] = (kind[k] == AX_LIMIT);
    end
  end

  // Merge rounds: running entry (max) and exit (min) with axis 1, then 2.
  // Each round holds three stages: the compare unit's two plus a select.
  logic signed [NB-1:0] en_n [3];
  logic        [DB-1:0] en_d [3];
  logic                 en_f [3];
  logic signed [NB-1:0] ex_n [3];
  logic        [DB-1:0] ex_d [3];
  logic                 ex_f [3];
  logic face_p [3];
  logic miss_p [3];
  // Delay line for axis 2.
  logic signed [NB-1:0] ax_nn [3];
  logic signed [NB-1:0] ax_nf [3];
  logic        [DB-1:0] ax_d  [3];
  logic                 ax_f  [3];

  assign en_n[0] = nn[0];
  assign en_d[0] = den[0];
  assign en_f[0] = fin1[0];
  assign ex_n[0] = nf[0];
  assign ex_d[0] = den[0];
  assign ex_f[0] = fin1[0];
  assign face_p[0] = face1;
  assign miss_p[0] = miss1;

  for (genvar r = 0; r < 2; r++) begin : g_rnd
    logic signed [NB-1:0] c_nn, c_nf, e_n [2], x_n [2];
    logic        [DB-1:0] c_d, e_d [2], x_d [2];
    logic                 c_f, e_f [2], x_f [2], fc [2], ms [2];
    logic                 gt, lt;
    logic signed [NB-1:0] s_en_n, s_ex_n;
    logic        [DB-1:0] s_en_d, s_ex_d;
    logic                 s_en_f, s_ex_f, s_fc, s_ms;

    assign c_nn = (r == 0) ? nn[1] : ax_nn[2];
    assign c_nf = (r == 0) ? nf[1] : ax_nf[2];
    assign c_d  = (r == 0) ? den[1] : ax_d[2];
    assign c_f  = (r == 0) ? fin1[1] : ax_f[2];

    aabb_cmp #(.NB(NB), .DB(DB)) u_ce (
      .clk(clk), .en(en), .n1(c_nn), .d1(c_d), .n2(en_n[r]), .d2(en_d[r]),
      .gt(gt), .lt());
    aabb_cmp #(.NB(NB), .DB(DB)) u_cx (
      .clk(clk), .en(en), .n1(c_nf), .d1(c_d), .n2(ex_n[r]), .d2(ex_d[r]),
      .gt(), .lt(lt));

    logic signed [NB-1:0] k_nn [2], k_nf [2];
    logic        [DB-1:0] k_d [2];
    logic                 k_f [2];
    always_ff @(posedge clk) begin
      if (en) begin
        e_n[0] <= en_n[r]; e_d[0] <= en_d[r]; e_f[0] <= en_f[r];
        x_n[0] <= ex_n[r]; x_d[0] <= ex_d[r]; x_f[0] <= ex_f[r];
        fc[0] <= face_p[r]; ms[0] <= miss_p[r];
        k_nn[0] <= c_nn; k_nf[0] <= c_nf; k_d[0] <= c_d; k_f[0] <= c_f;
        e_n[1] <= e_n[0]; e_d[1] <= e_d[0]; e_f[1] <= e_f[0];
        x_n[1] <= x_n[0]; x_d[1] <= x_d[0]; x_f[1] <= x_f[0];
        fc[1] <= fc[0]; ms[1] <= ms[0];
        k_nn[1] <= k_nn[0]; k_nf[1] <= k_nf[0]; k_d[1] <= k_d[0]; k_f[1] <= k_f[0];
        if (k_f[1] && (!e_f[1] || gt)) begin
          s_en_n <= k_nn[1]; s_en_d <= k_d[1]; s_en_f <= 1'b1;
        end else begin
          s_en_n <= e_n[1]; s_en_d <= e_d[1]; s_en_f <= e_f[1];
        end
        if (k_f[1] && (!x_f[1] || lt)) begin
          s_ex_n <= k_nf[1]; s_ex_d <= k_d[1]; s_ex_f <= 1'b1;
        end else begin
          s_ex_n <= x_n[1]; s_ex_d <= x_d[1]; s_ex_f <= x_f[1];
        end
        s_fc <= fc[1];
        s_ms <= ms[1];
      end
    end
    assign en_n[r+1] = s_en_n; assign en_d[r+1] = s_en_d; assign en_f[r+1] = s_en_f;
    assign ex_n[r+1] = s_ex_n; assign ex_d[r+1] = s_ex_d; assign ex_f[r+1] = s_ex_f;
    assign face_p[r+1] = s_fc;
    assign miss_p[r+1] = s_ms;
  end

  // Axis 2 waits three stages for the second round.
  always_ff @(posedge clk) begin
    if (en) begin
      ax_nn[0] <= nn[2]; ax_nf[0] <= nf[2]; ax_d[0] <= den[2];
      ax_f[0] <= fin1[2];
      for (int i = 1; i < 3; i++) begin
        ax_nn[i] <= ax_nn[i-1]; ax_nf[i] <= ax_nf[i-1];
        ax_d[i] <= ax_d[i-1]; ax_f[i] <= ax_f[i-1];
      end
    end
  end

  // Final stages: range tests against 0 and 1, and entry < exit.
  logic one_lt, one_gt_en, one_gt_ex;
  aabb_cmp #(.NB(NB), .DB(DB)) u_c1 (
    .clk(clk), .en(en), .n1(en_n[2]), .d1(en_d[2]), .n2(NB'(1)), .d2(DB'(1)),
    .gt(one_gt_en), .lt());
  aabb_cmp #(.NB(NB), .DB(DB)) u_c2 (
    .clk(clk), .en(en), .n1(ex_n[2]), .d1(ex_d[2]), .n2(NB'(1)), .d2(DB'(1)),
    .gt(one_gt_ex), .lt());
  aabb_cmp #(.NB(NB), .DB(DB)) u_c3 (
    .clk(clk), .en(en), .n1(en_n[2]), .d1(en_d[2]), .n2(ex_n[2]), .d2(ex_d[2]),
    .gt(), .lt(one_lt));

  logic [1:0] f_fc, f_ms, f_enf, f_exf, f_enneg, f_exneg;
  logic hit_q;
  always_ff @(posedge clk) begin
    if (en) begin
      f_fc  <= {f_fc[0], face_p[2]};
      f_ms  <= {f_ms[0], miss_p[2]};
      f_enf <= {f_enf[0], en_f[2]};
      f_exf <= {f_exf[0], ex_f[2]};
      f_enneg <= {f_enneg[0], en_n[2][NB-1]};
      f_exneg <= {f_exneg[0], ex_n[2][NB-1]};
      if (f_fc[1]) hit_q <= 1'b1;
      else if (f_ms[1]) hit_q <= 1'b0;
      else if (((!f_enf[1] || f_enneg[1]) && (f_exf[1] && f_exneg[1])) ||
               ((f_enf[1] && one_gt_en) && (!f_exf[1] || one_gt_ex)))
        hit_q <= 1'b0;
      else if (!f_enf[1] || !f_exf[1]) hit_q <= 1'b1;
      else hit_q <= one_lt;
    end
  end
  assign out_req.data = hit_q;

  `ASSERT_NEXT(a_stall_hold, clk, rst, out_req.valid && !out_req.ready, out_req.valid)
  `ASSERT_IMPL(a_ready_rule, clk, rst, !out_req.ready && out_req.valid, !in_req.ready)
  `ASSERT_NEXT(a_flow, clk, rst, en && in_req.valid, vld[0])
endmodule

// ===== rtl/aabb_cmp.sv =====
// Sign of n1/d1 - n2/d2 for positive denominators, as a registered
// two-stage unit: products first, compare second.
module aabb_cmp
  import aabb_pkg::*;
#(
  parameter int NB = 34,
  parameter int DB = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NB-1:0] n1,
  input  logic        [DB-1:0] d1,
  input  logic signed [NB-1:0] n2,
  input  logic        [DB-1:0] d2,
  output logic                 gt,
  output logic                 lt
);
  logic signed [NB+DB:0] p1;
  logic signed [NB+DB:0] p2;

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= n1 * $signed({1'b0, d2});
      p2 <= n2 * $signed({1'b0, d1});
      gt <= p1 > p2;
      lt <= p1 < p2;
    end
  end
endmodule

// ===== rtl/aabb_axis.sv =====
// First stage for one axis: differences, direction sign fold, order of the
// two slab numerators, and the zero-direction classification.
module aabb_axis
  import aabb_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [CW-1:0] lo,
  input  logic signed [CW-1:0] hi,
  input  logic signed [CW-1:0] org,
  input  logic signed [CW-1:0] dir,
  output logic signed [CW+1:0] nn,
  output logic signed [CW+1:0] nf,
  output logic        [CW:0]   den,
  output logic [1:0]           kind
);
  logic signed [CW+1:0] a;
  logic signed [CW+1:0] b;
  logic signed [CW+1:0] dx;
  logic                 zero;

  always_comb begin
    a    = (CW+2)'(lo) - (CW+2)'(org);
    b    = (CW+2)'(hi) - (CW+2)'(org);
    dx   = (CW+2)'(dir);
    zero = (dir == '0);
    if (dir < 0) begin
      a  = -a;
      b  = -b;
      dx = -dx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn  <= (a < b) ? a : b;
      nf  <= (a < b) ? b : a;
      den <= dx[CW:0];
      if (!zero) kind <= AX_LIMIT;
      else if (a == 0 || b == 0) kind <= AX_FACE;
      else if (a[CW+1] == b[CW+1]) kind <= AX_MISS;
      else kind <= AX_FREE;
    end
  end
endmodule
